@@ src/cfcp_pkg.sv @@
// Shared types, constants and helper functions for the class file constant pool parser.
// Used by the front, back and top-level modules; depends on nothing else.
package cfcp_pkg;

    // Default depths of the queue between front and back and of the result queue.
    localparam int MID_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_POOL_ENTRY  = 3'd1;
    localparam logic [2:0] KIND_UTF8_BYTE   = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN_TAG = 3'd4;

    // Constant pool tags.
    localparam logic [7:0] TAG_UTF8           = 8'd1;
    localparam logic [7:0] TAG_INTEGER        = 8'd3;
    localparam logic [7:0] TAG_FLOAT          = 8'd4;
    localparam logic [7:0] TAG_LONG           = 8'd5;
    localparam logic [7:0] TAG_DOUBLE         = 8'd6;
    localparam logic [7:0] TAG_CLASS          = 8'd7;
    localparam logic [7:0] TAG_STRING         = 8'd8;
    localparam logic [7:0] TAG_FIELDREF       = 8'd9;
    localparam logic [7:0] TAG_METHODREF      = 8'd10;
    localparam logic [7:0] TAG_IFACE_METHODREF = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE  = 8'd12;

    // Body length class of a fixed-size entry.
    typedef enum logic [1:0] {
        BODY_NONE = 2'd0,
        BODY_2    = 2'd1,
        BODY_4    = 2'd2,
        BODY_8    = 2'd3
    } body_len_t;

    // One classified input byte, as passed from front to back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       is_utf8;
        body_len_t  body_len;
        logic       two_fields;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] entry_index;
        logic [7:0]  entry_tag;
        logic [31:0] value_high;
        logic [31:0] value_low;
        logic        last;
    } result_t;

    function automatic body_len_t classify_body(input logic [7:0] tag);
        body_len_t len;
        case (tag)
            TAG_CLASS, TAG_STRING:                   len = BODY_2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF,
            TAG_METHODREF, TAG_IFACE_METHODREF,
            TAG_NAME_AND_TYPE:                       len = BODY_4;
            TAG_LONG, TAG_DOUBLE:                    len = BODY_8;
            default:                                 len = BODY_NONE;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] body_bytes(input body_len_t len);
        logic [3:0] n;
        unique case (len)
            BODY_2:  n = 4'd2;
            BODY_4:  n = 4'd4;
            BODY_8:  n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ src/cfcp_queue.sv @@
// Small first-in first-out queue of fixed-width items, used between front and back
// and in front of the result ports. Depends on nothing else.
module cfcp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2     // two or more entries
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/cfcp_front.sv @@
// Front end of the parser: takes bytes in and classifies each as a possible tag.
// Depends on cfcp_pkg; feeds the queue in front of cfcp_back.
module cfcp_front (
    input  logic            push,
    input  logic [7:0]      data_byte,
    input  logic            start_of_file,
    output logic            full,
    output logic            mid_push,
    output cfcp_pkg::item_t mid_item,
    input  logic            mid_full
);
    import cfcp_pkg::*;

    body_len_t len;

    // The tag class is worked out for every byte; the back end uses it only
    // when it is waiting for a tag.
    assign len                    = classify_body(data_byte);
    assign mid_item.data_byte     = data_byte;
    assign mid_item.start_of_file = start_of_file;
    assign mid_item.is_utf8       = (data_byte == TAG_UTF8);
    assign mid_item.body_len      = len;
    assign mid_item.two_fields    = (len == BODY_4) && (data_byte >= TAG_FIELDREF);

    assign full     = mid_full;
    assign mid_push = push && !mid_full;

endmodule

@@ src/cfcp_back.sv @@
// Back end of the parser: the state machine that walks magic, header and pool entries.
// Depends on cfcp_pkg; reads classified items and writes result items to queues.
module cfcp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mid_empty,
    input  cfcp_pkg::item_t   mid_item,
    output logic              mid_pop,
    input  logic              out_full,
    output logic              out_push,
    output cfcp_pkg::result_t out_result
);
    import cfcp_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_MAGIC  = 8'b0000_0010,
        PH_HEADER = 8'b0000_0100,
        PH_TAG    = 8'b0000_1000,
        PH_FIELDS = 8'b0001_0000,
        PH_ULEN   = 8'b0010_0000,
        PH_UBYTES = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [63:0] field_shift_reg, field_shift_next;
    logic [15:0] pool_count_reg, pool_count_next;
    logic [15:0] current_index_reg, current_index_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    body_len_t   cur_len_reg, cur_len_next;
    logic        cur_pair_reg, cur_pair_next;
    logic [15:0] text_remaining_reg, text_remaining_next;
    logic [15:0] text_offset_reg, text_offset_next;

    logic [63:0] shift_in;
    logic [3:0]  count_inc;
    logic [15:0] remaining_dec;
    logic        emit;
    logic        do_advance;
    logic [1:0]  advance_step;
    logic [16:0] advance_index;
    logic        advance_last;
    result_t     res;

    assign mid_pop       = !mid_empty && !out_full;
    assign shift_in      = {field_shift_reg[55:0], mid_item.data_byte};
    assign count_inc     = byte_count_reg + 4'd1;
    assign remaining_dec = text_remaining_reg - 16'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        field_shift_next    = field_shift_reg;
        pool_count_next     = pool_count_reg;
        current_index_next  = current_index_reg;
        current_tag_next    = current_tag_reg;
        cur_len_next        = cur_len_reg;
        cur_pair_next       = cur_pair_reg;
        text_remaining_next = text_remaining_reg;
        text_offset_next    = text_offset_reg;
        emit                = 1'b0;
        do_advance          = 1'b0;
        advance_step        = 2'd1;
        advance_last        = 1'b0;
        res                 = '0;

        if (mid_pop)
        begin
            if (mid_item.start_of_file)
            begin
                phase_next       = PH_MAGIC;
                byte_count_next  = 4'd1;
                field_shift_next = {56'd0, mid_item.data_byte};
            end
            else
            begin
                unique case (phase_reg)
                    PH_MAGIC:
                    begin
                        field_shift_next = shift_in;
                        byte_count_next  = count_inc;
                        if (count_inc >= 4'd4)
                        begin
                            if (shift_in[31:0] != MAGIC_WORD)
                            begin
                                emit            = 1'b1;
                                res.result_kind = KIND_BAD_MAGIC;
                                res.value_low   = shift_in[31:0];
                                res.last        = 1'b1;
                                phase_next      = PH_IDLE;
                                byte_count_next = 4'd0;
                            end
                            else
                            begin
                                phase_next       = PH_HEADER;
                                byte_count_next  = 4'd0;
                                field_shift_next = '0;
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        field_shift_next = shift_in;
                        byte_count_next  = count_inc;
                        if (count_inc >= 4'd6)
                        begin
                            // Bytes arrive as minor, major, pool count.
                            pool_count_next    = shift_in[15:0];
                            current_index_next = 16'd1;
                            byte_count_next    = 4'd0;
                            field_shift_next   = '0;
                            emit               = 1'b1;
                            res.result_kind    = KIND_HEADER;
                            res.value_high     = {shift_in[31:16], shift_in[47:32]};
                            res.value_low      = {16'd0, shift_in[15:0]};
                            res.last           = (shift_in[15:0] <= 16'd1);
                            phase_next         = res.last ? PH_DONE : PH_TAG;
                        end
                    end
                    PH_TAG:
                    begin
                        current_tag_next = mid_item.data_byte;
                        cur_len_next     = mid_item.body_len;
                        cur_pair_next    = mid_item.two_fields;
                        byte_count_next  = 4'd0;
                        field_shift_next = '0;
                        if (mid_item.is_utf8)
                        begin
                            phase_next = PH_ULEN;
                        end
                        else if (mid_item.body_len != BODY_NONE)
                        begin
                            phase_next = PH_FIELDS;
                        end
                        else
                        begin
                            emit            = 1'b1;
                            do_advance      = 1'b1;
                            res.result_kind = KIND_UNKNOWN_TAG;
                            res.entry_index = current_index_reg;
                            res.entry_tag   = mid_item.data_byte;
                        end
                    end
                    PH_FIELDS:
                    begin
                        field_shift_next = shift_in;
                        byte_count_next  = count_inc;
                        if (count_inc >= body_bytes(cur_len_reg))
                        begin
                            emit            = 1'b1;
                            do_advance      = 1'b1;
                            res.result_kind = KIND_POOL_ENTRY;
                            res.entry_index = current_index_reg;
                            res.entry_tag   = current_tag_reg;
                            if (cur_len_reg == BODY_8)
                            begin
                                advance_step   = 2'd2;
                                res.value_high = shift_in[63:32];
                                res.value_low  = shift_in[31:0];
                            end
                            else if (cur_pair_reg)
                            begin
                                res.value_high = {16'd0, shift_in[31:16]};
                                res.value_low  = {16'd0, shift_in[15:0]};
                            end
                            else
                            begin
                                res.value_low = shift_in[31:0];
                            end
                        end
                    end
                    PH_ULEN:
                    begin
                        field_shift_next = shift_in;
                        byte_count_next  = count_inc;
                        if (count_inc >= 4'd2)
                        begin
                            text_remaining_next = shift_in[15:0];
                            text_offset_next    = 16'd0;
                            emit                = 1'b1;
                            res.result_kind     = KIND_POOL_ENTRY;
                            res.entry_index     = current_index_reg;
                            res.entry_tag       = TAG_UTF8;
                            res.value_low       = {16'd0, shift_in[15:0]};
                            if (shift_in[15:0] == 16'd0)
                            begin
                                do_advance = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_UBYTES;
                            end
                        end
                    end
                    PH_UBYTES:
                    begin
                        text_offset_next    = text_offset_reg + 16'd1;
                        text_remaining_next = remaining_dec;
                        emit                = 1'b1;
                        res.result_kind     = KIND_UTF8_BYTE;
                        res.entry_index     = current_index_reg;
                        res.entry_tag       = TAG_UTF8;
                        res.value_high      = {16'd0, text_offset_reg};
                        res.value_low       = {24'd0, mid_item.data_byte};
                        do_advance          = (remaining_dec == 16'd0);
                    end
                    default:
                    begin
                        // Idle or done: the byte is dropped.
                    end
                endcase
            end
        end

        // Step to the next pool index; reaching the count ends the pool.
        advance_index = {1'b0, current_index_reg} + {15'd0, advance_step};
        if (do_advance)
        begin
            current_index_next = advance_index[15:0];
            if (advance_index >= {1'b0, pool_count_reg})
            begin
                phase_next   = PH_DONE;
                advance_last = 1'b1;
            end
            else
            begin
                phase_next       = PH_TAG;
                byte_count_next  = 4'd0;
                field_shift_next = '0;
            end
        end

        out_result      = res;
        out_result.last = res.last | advance_last;
        out_push        = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            byte_count_reg     <= '0;
            field_shift_reg    <= '0;
            pool_count_reg     <= '0;
            current_index_reg  <= '0;
            current_tag_reg    <= '0;
            cur_len_reg        <= BODY_NONE;
            cur_pair_reg       <= 1'b0;
            text_remaining_reg <= '0;
            text_offset_reg    <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            field_shift_reg    <= field_shift_next;
            pool_count_reg     <= pool_count_next;
            current_index_reg  <= current_index_next;
            current_tag_reg    <= current_tag_next;
            cur_len_reg        <= cur_len_next;
            cur_pair_reg       <= cur_pair_next;
            text_remaining_reg <= text_remaining_next;
            text_offset_reg    <= text_offset_next;
        end
    end

endmodule

@@ src/class_file_constant_pool_parser.sv @@
// Top level of the class file constant pool parser: front, back and two queues.
// Depends on cfcp_pkg, cfcp_front, cfcp_queue and cfcp_back.
//
// Usage. The block reads a class file one byte per item on the input queue port:
// an item is taken at a rising edge with push high and full low. Raise
// start_of_file with the first magic byte to begin a file; this restarts the
// parser from any point. Results leave through the output queue port: while
// empty is low the oldest result item is on the result ports, and it is taken at
// an edge with pop high. A result carries the header, a decoded pool entry, one
// Utf8 text byte, a bad magic report or an unknown tag report; last marks the
// result that ends the pool or ends parsing. Bytes after the pool, before any
// start, or after a bad magic are dropped without a result.
// Timing. A byte is registered in the queue between front and back; the back end
// decodes it, and any result is registered in the result queue that drives the ports.
// The parser state is updated once per byte, so the block sustains one byte per cycle while the result queue has room.
// Reset. rst_n clears both queues and leaves the parser idle awaiting a start.
// Stall. If results are not popped the result queue fills, the back end stops,
// the queue between front and back fills, and full rises; nothing is lost.
module class_file_constant_pool_parser #(
    parameter int MID_DEPTH = cfcp_pkg::MID_QUEUE_DEPTH,
    parameter int OUT_DEPTH = cfcp_pkg::OUT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [15:0] entry_index,
    output logic [7:0]  entry_tag,
    output logic [31:0] value_high,
    output logic [31:0] value_low,
    output logic        last
);
    import cfcp_pkg::*;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    // Front to queue.
    logic    mid_push;
    item_t   mid_in;
    logic    mid_full;
    // Queue to back.
    logic    mid_pop;
    item_t   mid_out;
    logic    mid_empty;
    // Back to result queue.
    logic    out_push;
    result_t out_in;
    logic    out_full;
    result_t out_head;

    cfcp_front u_front (
        .push          (push),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .full          (full),
        .mid_push      (mid_push),
        .mid_item      (mid_in),
        .mid_full      (mid_full)
    );

    // The queue between front and back absorbs stalls on the result side.
    cfcp_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty)
    );

    cfcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_empty  (mid_empty),
        .mid_item   (mid_out),
        .mid_pop    (mid_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_result (out_in)
    );

    // Result queue: the receiver sees its head on the result ports.
    cfcp_queue #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_in),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_head),
        .empty     (empty)
    );

    assign result_kind = out_head.result_kind;
    assign entry_index = out_head.entry_index;
    assign entry_tag   = out_head.entry_tag;
    assign value_high  = out_head.value_high;
    assign value_low   = out_head.value_low;
    assign last        = out_head.last;

`ifndef SYNTHESIS
    // The back end only writes a result when the result queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result written into a full result queue");

    // A bad magic report always ends parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_BAD_MAGIC) |-> last)
        else $error("bad magic report without last");

    // Header and bad magic results carry neither index nor tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result_kind == KIND_HEADER || result_kind == KIND_BAD_MAGIC))
        |-> (entry_index == 16'd0 && entry_tag == 8'd0))
        else $error("header or bad magic result with index or tag set");

    // Text bytes belong to Utf8 entries only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_UTF8_BYTE) |-> entry_tag == TAG_UTF8)
        else $error("text byte result outside a Utf8 entry");
`endif

endmodule
